// ===== hw/rtl/sae_pkg.sv =====
package sae_pkg;

   localparam int ALPHABET_SIZE_DEF = 256;

   localparam logic [31:0] TOP_VAL   = 32'hFFFF_FFFF;
   localparam logic [31:0] HALF_VAL  = 32'h8000_0000;
   localparam logic [31:0] QTR1_VAL  = 32'h4000_0000;
   localparam logic [31:0] QTR3_VAL  = 32'hC000_0000;
   localparam logic [30:0] MAX_TOTAL = 31'h4000_0000;
   localparam logic [30:0] SAT_COUNT = 31'h7FFF_FFFF;

   localparam logic KIND_BIT    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_BIG  = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_PREPARE = 2'd1,
      OP_ENCODE  = 2'd2,
      OP_FINISH  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP_RD,
      S_PREP_ACC,
      S_PREP_DONE,
      S_ENC_RD0,
      S_ENC_RD1,
      S_ENC_LD,
      S_ENC_DIV,
      S_ENC_UPD,
      S_ENC_REN,
      S_ENC_END,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        kind;
      logic        bit_res;
      logic [31:0] follow_count;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic mem_clear_wr;
      logic idx_inc;
      logic load_wr;
      logic prep_init;
      logic prep_rd;
      logic prep_acc;
      logic prep_fin;
      logic push_status;
      logic enc_cap;
      logic enc_rd_lo;
      logic enc_rd_hi;
      logic enc_ld;
      logic div_step;
      logic enc_upd;
      logic ren_step;
      logic push_last;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic sym_ok;
      logic model_ok;
      logic idx_last;
      logic div_last;
      logic ren_done;
      logic hold_valid;
   } sts_type;

endpackage

// ===== hw/rtl/sae_if.sv =====
interface sae_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [7:0]  symbol;
   logic [30:0] count;

   modport source(output valid, opcode, symbol, count, input ready);
   modport sink(input valid, opcode, symbol, count, output ready);
endinterface

interface sae_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        bit_res;
   logic [31:0] follow_count;
   logic [1:0]  status;
   logic        last;

   modport source(output valid, kind, bit_res, follow_count, status, last, input ready);
   modport sink(input valid, kind, bit_res, follow_count, status, last, output ready);
endinterface

// ===== hw/rtl/sae_ctrl.sv =====
module sae_ctrl import sae_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic [1:0] req_opcode,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.mem_clear_wr = 1'b1;
            cmd.idx_inc      = 1'b1;
            if (sts.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               case (op_type'(req_opcode))
                  OP_LOAD: cmd.load_wr = 1'b1;
                  OP_PREPARE: begin
                     cmd.prep_init = 1'b1;
                     state_in      = S_PREP_RD;
                  end
                  OP_ENCODE: begin
                     // An out-of-range symbol or an unusable model drops the request.
                     if (sts.sym_ok && sts.model_ok) begin
                        cmd.enc_cap = 1'b1;
                        state_in    = S_ENC_RD0;
                     end
                  end
                  OP_FINISH: state_in = S_FINISH;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PREP_RD: begin
            cmd.prep_rd = 1'b1;
            state_in    = S_PREP_ACC;
         end
         S_PREP_ACC: begin
            cmd.prep_acc = 1'b1;
            cmd.idx_inc  = 1'b1;
            if (sts.idx_last) begin
               cmd.prep_fin = 1'b1;
               state_in     = S_PREP_DONE;
            end else begin
               state_in = S_PREP_RD;
            end
         end
         S_PREP_DONE: begin
            if (sts.slot_free) begin
               cmd.push_status = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_ENC_RD0: begin
            cmd.enc_rd_lo = 1'b1;
            state_in      = S_ENC_RD1;
         end
         S_ENC_RD1: begin
            cmd.enc_rd_hi = 1'b1;
            state_in      = S_ENC_LD;
         end
         S_ENC_LD: begin
            cmd.enc_ld = 1'b1;
            state_in   = S_ENC_DIV;
         end
         S_ENC_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_ENC_UPD;
         end
         S_ENC_UPD: begin
            cmd.enc_upd = 1'b1;
            state_in    = S_ENC_REN;
         end
         S_ENC_REN: begin
            if (sts.ren_done) begin
               state_in = S_ENC_END;
            end else begin
               cmd.ren_step = 1'b1;
            end
         end
         S_ENC_END: begin
            if (!sts.hold_valid) begin
               state_in = S_IDLE;
            end else if (sts.slot_free) begin
               cmd.push_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FINISH: begin
            if (sts.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/sae_dp.sv =====
module sae_dp import sae_pkg::*; #(
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [7:0]  req_symbol,
   input  logic [30:0] req_count,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int AW = $clog2(ALPHABET_SIZE);
   localparam int CW = $clog2(ALPHABET_SIZE + 1);

   logic [30:0] sym_mem [ALPHABET_SIZE];
   logic [30:0] cum_mem [ALPHABET_SIZE + 1];

   logic [AW-1:0] idx_ff;
   logic [CW-1:0] sym_ff;
   logic [30:0]   sym_rd_ff, cum_rd_ff, cum_lo_ff, cum_hi_ff;
   logic [30:0]   run_ff, total_ff;
   logic [31:0]   low_ff, high_ff, pf_ff;
   logic [32:0]   range_ff;
   logic [5:0]    div_cnt_ff;
   logic [30:0]   rem_lo_ff, rem_hi_ff;
   logic [32:0]   q_lo_ff, q_hi_ff;
   logic          hold_valid_ff, hold_bit_ff;
   logic [31:0]   hold_follow_ff;
   logic          out_valid_ff;
   rsp_type       out_ff;

   logic [31:0]   sym_wide;
   logic          slot_free;
   logic [31:0]   run_sum;
   logic [30:0]   run_sat;
   logic [31:0]   pf_inc;
   logic          e0, e1, ef, emit, ren_done, ren_go, ren_push;
   logic [31:0]   sub_val, low_sub, high_sub;
   logic [1:0]    st_calc;
   logic [30:0]   lo_k, hi_k;
   logic [32:0]   lo_qn, hi_qn;

   assign sym_wide  = 32'(req_symbol);
   assign slot_free = !out_valid_ff || rsp_ready;

   assign run_sum = {1'b0, run_ff} + {1'b0, sym_rd_ff};
   assign run_sat = run_sum[31] ? SAT_COUNT : run_sum[30:0];
   assign pf_inc  = (pf_ff == TOP_VAL) ? pf_ff : pf_ff + 32'd1;

   assign e0       = high_ff < HALF_VAL;
   assign e1       = !e0 && (low_ff >= HALF_VAL);
   assign ef       = !e0 && !e1 && (low_ff >= QTR1_VAL) && (high_ff < QTR3_VAL);
   assign emit     = e0 || e1;
   assign ren_done = !(emit || ef);
   // A second emitted bit waits until the held one can move to the output register.
   assign ren_go   = cmd.ren_step && !ren_done && !(emit && hold_valid_ff && !slot_free);
   assign ren_push = ren_go && emit && hold_valid_ff;
   assign sub_val  = e1 ? HALF_VAL : (ef ? QTR1_VAL : 32'd0);
   assign low_sub  = low_ff - sub_val;
   assign high_sub = high_ff - sub_val;

   always_comb begin
      if (total_ff == 31'd0) begin
         st_calc = ST_ZERO;
      end else if (total_ff > MAX_TOTAL) begin
         st_calc = ST_BIG;
      end else begin
         st_calc = ST_OK;
      end
   end

   // One step of (range * count) / total: the range is taken MSB first and the
   // partial remainder stays below the total, so each step subtracts at most two totals.
   function automatic logic [32:0] div_step_fn(input logic [30:0] rem, input logic b,
                                               input logic [30:0] c, input logic [30:0] tot,
                                               output logic [30:0] rem_out);
      logic [32:0] t, t1, t2;
      logic [1:0]  k;
      t  = {1'b0, rem, 1'b0} + (b ? {2'b00, c} : 33'd0);
      t1 = t - {2'b00, tot};
      t2 = t - {1'b0, tot, 1'b0};
      if (!t2[32]) begin
         rem_out = t2[30:0];
         k       = 2'd2;
      end else if (!t1[32]) begin
         rem_out = t1[30:0];
         k       = 2'd1;
      end else begin
         rem_out = t[30:0];
         k       = 2'd0;
      end
      div_step_fn = {31'd0, k};
   endfunction

   always_comb begin
      lo_qn = {q_lo_ff[31:0], 1'b0} + div_step_fn(rem_lo_ff, range_ff[32], cum_lo_ff,
                                                   total_ff, lo_k);
      hi_qn = {q_hi_ff[31:0], 1'b0} + div_step_fn(rem_hi_ff, range_ff[32], cum_hi_ff,
                                                   total_ff, hi_k);
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (cmd.mem_clear_wr) begin
         sym_mem[idx_ff] <= '0;
      end else if (cmd.load_wr && sts.sym_ok) begin
         sym_mem[sym_wide[AW-1:0]] <= req_count;
      end
      if (cmd.prep_rd) sym_rd_ff <= sym_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.prep_init) begin
         cum_mem[CW'(0)] <= '0;
      end else if (cmd.prep_acc) begin
         cum_mem[CW'(idx_ff) + CW'(1)] <= run_sat;
      end
      if (cmd.enc_rd_lo) begin
         cum_rd_ff <= cum_mem[sym_ff];
      end else if (cmd.enc_rd_hi) begin
         cum_rd_ff <= cum_mem[sym_ff + CW'(1)];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         total_ff      <= '0;
         low_ff        <= '0;
         high_ff       <= TOP_VAL;
         pf_ff         <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         if (cmd.prep_init) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + AW'(1);
         end

         if (cmd.prep_fin) total_ff <= run_sat;

         if (cmd.prep_fin || cmd.finish) begin
            low_ff  <= '0;
            high_ff <= TOP_VAL;
            pf_ff   <= '0;
         end else if (cmd.enc_upd) begin
            high_ff <= low_ff + q_hi_ff[31:0] - 32'd1;
            low_ff  <= low_ff + q_lo_ff[31:0];
         end else if (ren_go) begin
            low_ff  <= {low_sub[30:0], 1'b0};
            high_ff <= {high_sub[30:0], 1'b1};
            pf_ff   <= emit ? 32'd0 : pf_inc;
         end

         if (ren_go && emit) begin
            hold_valid_ff <= 1'b1;
         end else if (cmd.push_last) begin
            hold_valid_ff <= 1'b0;
         end

         if (cmd.enc_ld) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 6'd1;
         end

         if (cmd.push_status || cmd.push_last || cmd.finish || ren_push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.prep_init) run_ff <= '0;
      else if (cmd.prep_acc) run_ff <= run_sat;

      if (cmd.enc_cap) sym_ff <= sym_wide[CW-1:0];
      if (cmd.enc_rd_hi) cum_lo_ff <= cum_rd_ff;

      if (cmd.enc_ld) begin
         cum_hi_ff <= cum_rd_ff;
         range_ff  <= {1'b0, high_ff} - {1'b0, low_ff} + 33'd1;
         rem_lo_ff <= '0;
         rem_hi_ff <= '0;
         q_lo_ff   <= '0;
         q_hi_ff   <= '0;
      end else if (cmd.div_step) begin
         range_ff  <= {range_ff[31:0], 1'b0};
         rem_lo_ff <= lo_k;
         rem_hi_ff <= hi_k;
         q_lo_ff   <= lo_qn;
         q_hi_ff   <= hi_qn;
      end

      if (ren_go && emit) begin
         hold_bit_ff    <= e1;
         hold_follow_ff <= pf_ff;
      end

      if (cmd.push_status) begin
         out_ff <= '{KIND_STATUS, 1'b0, 32'd0, st_calc, 1'b1};
      end else if (cmd.finish) begin
         out_ff <= '{KIND_BIT, (low_ff >= QTR1_VAL), pf_inc, ST_OK, 1'b1};
      end else if (cmd.push_last) begin
         out_ff <= '{KIND_BIT, hold_bit_ff, hold_follow_ff, ST_OK, 1'b1};
      end else if (ren_push) begin
         out_ff <= '{KIND_BIT, hold_bit_ff, hold_follow_ff, ST_OK, 1'b0};
      end
   end

   assign sts.slot_free  = slot_free;
   assign sts.sym_ok     = sym_wide < 32'(ALPHABET_SIZE);
   assign sts.model_ok   = (total_ff != 31'd0) && (total_ff <= MAX_TOTAL);
   assign sts.idx_last   = idx_ff == AW'(ALPHABET_SIZE - 1);
   assign sts.div_last   = div_cnt_ff == 6'd32;
   assign sts.ren_done   = ren_done;
   assign sts.hold_valid = hold_valid_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== hw/rtl/static_arithmetic_encoder_top.sv =====
// Channel  Direction  Contents
// req_bus  in         opcode, symbol, count
// rsp_bus  out        kind, bit_res, follow_count, status, last
//
// A prepare makes one table read and one running-sum write per symbol.
// An encode runs the 33-step shared-range divider and then up to 32
// renormalization steps.
// After reset the count table is cleared one entry a cycle.
// A result waiting in the output register holds the controller, and with it the
// request side, only when another result must be pushed, until the first is taken.
module static_arithmetic_encoder_top import sae_pkg::*; #(
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input logic        clock,
   input logic        reset,
   sae_req_if.sink    req_bus,
   sae_rsp_if.source  rsp_bus
);

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_data;

   sae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sae_dp #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_symbol (req_bus.symbol),
      .req_count  (req_bus.count),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_data   (rsp_data)
   );

   assign rsp_bus.kind         = rsp_data.kind;
   assign rsp_bus.bit_res      = rsp_data.bit_res;
   assign rsp_bus.follow_count = rsp_data.follow_count;
   assign rsp_bus.status       = rsp_data.status;
   assign rsp_bus.last         = rsp_data.last;

endmodule

// ===== hw/rtl/sae_checker.sv =====
module sae_checker import sae_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic        rsp_bit_res,
   input logic [31:0] rsp_follow_count,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_bit_res)
         && $stable(rsp_follow_count) && $stable(rsp_status) && $stable(rsp_last))
      else $error("response changed while stalled");

   // The count table is being cleared right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during the clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |-> rsp_last && !rsp_bit_res
         && rsp_follow_count == 32'd0)
      else $error("malformed status response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_BIT |-> rsp_status == ST_OK)
      else $error("coded bit response carries a status");

endmodule

bind static_arithmetic_encoder_top sae_checker u_sae_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_kind         (rsp_bus.kind),
   .rsp_bit_res      (rsp_bus.bit_res),
   .rsp_follow_count (rsp_bus.follow_count),
   .rsp_status       (rsp_bus.status),
   .rsp_last         (rsp_bus.last)
);

// ===== tb/tb_static_arithmetic_encoder_top.sv =====
`timescale 1ns / 1ps
module tb_static_arithmetic_encoder_top;
   import sae_pkg::*;

   typedef struct {
      op_type      opcode;
      logic [7:0]  symbol;
      logic [30:0] count;
   } req_item_type;

   localparam int WATCHDOG_LIMIT = 40000;

   logic clock;
   logic reset;

   sae_req_if req_bus();
   sae_rsp_if rsp_bus();

   static_arithmetic_encoder_top uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   req_item_type pending_reqs[$];
   rsp_type   coded_expect[$];
   logic [7:0] dirty_syms[$];
   int        error_count = 0;
   bit        stimulus_done = 0;
   int        idle_cycles = 0;
   int        send_gap = 0;
   int        recv_gap = 0;

   // Predictor state.
   logic [30:0] freq_table[256];
   logic [30:0] cum_table[257];
   logic [30:0] model_total;
   logic [31:0] low_reg;
   logic [31:0] high_reg;
   logic [31:0] follow_reg;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic rsp_type make_rsp(logic kind, logic b, logic [31:0] fol,
                                        logic [1:0] st, logic lst);
      rsp_type r;
      r.kind = kind;
      r.bit_res = b;
      r.follow_count = fol;
      r.status = st;
      r.last = lst;
      return r;
   endfunction

   task automatic push_bit(logic b);
      coded_expect.push_back(make_rsp(KIND_BIT, b, follow_reg, ST_OK, 1'b0));
      follow_reg = 0;
   endtask

   task automatic predict_encoder(req_item_type it);
      logic [63:0] run;
      logic [63:0] span;
      logic [63:0] lo_c;
      logic [63:0] hi_c;
      logic [1:0]  st;
      int          produced;
      rsp_type     r;
      produced = 0;
      case (it.opcode)
         OP_LOAD: freq_table[it.symbol] = it.count;
         OP_PREPARE: begin
            run = 0;
            cum_table[0] = 0;
            for (int i = 0; i < 256; i++) begin
               run += freq_table[i];
               if (run > 64'h7FFF_FFFF) run = 64'h7FFF_FFFF;
               cum_table[i + 1] = run[30:0];
            end
            model_total = run[30:0];
            low_reg = 0;
            high_reg = TOP_VAL;
            follow_reg = 0;
            st = ST_OK;
            if (model_total == 0) st = ST_ZERO;
            else if (model_total > MAX_TOTAL) st = ST_BIG;
            coded_expect.push_back(make_rsp(KIND_STATUS, 1'b0, 32'd0, st, 1'b1));
         end
         OP_ENCODE: begin
            if (model_total != 0 && model_total <= MAX_TOTAL) begin
               span = {32'd0, high_reg} - {32'd0, low_reg} + 1;
               lo_c = cum_table[it.symbol];
               hi_c = cum_table[it.symbol + 1];
               high_reg = 32'(low_reg + (span * hi_c) / model_total - 1);
               low_reg = 32'(low_reg + (span * lo_c) / model_total);
               forever begin
                  if (high_reg < HALF_VAL) begin
                     push_bit(1'b0);
                     produced++;
                  end else if (low_reg >= HALF_VAL) begin
                     push_bit(1'b1);
                     produced++;
                     low_reg -= HALF_VAL;
                     high_reg -= HALF_VAL;
                  end else if (low_reg >= QTR1_VAL && high_reg < QTR3_VAL) begin
                     if (follow_reg != TOP_VAL) follow_reg++;
                     low_reg -= QTR1_VAL;
                     high_reg -= QTR1_VAL;
                  end else begin
                     break;
                  end
                  low_reg = low_reg << 1;
                  high_reg = (high_reg << 1) | 32'd1;
               end
               if (produced > 0) begin
                  r = coded_expect.pop_back();
                  r.last = 1'b1;
                  coded_expect.push_back(r);
               end
            end
         end
         OP_FINISH: begin
            if (follow_reg != TOP_VAL) follow_reg++;
            coded_expect.push_back(make_rsp(KIND_BIT, low_reg >= QTR1_VAL, follow_reg,
                                            ST_OK, 1'b1));
            low_reg = 0;
            high_reg = TOP_VAL;
            follow_reg = 0;
         end
      endcase
   endtask

   // Symbols loaded with a nonzero count are remembered so the next model can clear them.
   task automatic queue_req(op_type op, logic [7:0] sym, logic [30:0] cnt);
      req_item_type it;
      it.opcode = op;
      it.symbol = sym;
      it.count = cnt;
      pending_reqs.push_back(it);
      if (op == OP_LOAD && cnt != 0) dirty_syms.push_back(sym);
   endtask

   // Small random model over a few symbols, mostly usable.
   task automatic queue_model(output logic [7:0] used[$]);
      int n;
      logic [7:0] s;
      logic [7:0] stale[$];
      used = {};
      stale = dirty_syms;
      dirty_syms = {};
      foreach (stale[i]) queue_req(OP_LOAD, stale[i], 31'd0);
      n = $urandom_range(2, 6);
      for (int i = 0; i < n; i++) begin
         s = 8'($urandom);
         used.push_back(s);
         case ($urandom_range(0, 3))
            0: queue_req(OP_LOAD, s, 31'($urandom_range(1, 3)));
            1: queue_req(OP_LOAD, s, 31'($urandom_range(1, 1000)));
            2: queue_req(OP_LOAD, s, 31'($urandom_range(1, 32'h0FFF_FFFF)));
            default: queue_req(OP_LOAD, s, 31'($urandom_range(1, 32'h3FFF_FFFF) / n));
         endcase
      end
      queue_req(OP_PREPARE, 8'd0, 31'($urandom));
   endtask

   initial begin
      logic [7:0] used[$];
      // Directed part.
      queue_req(OP_FINISH, 8'd0, 31'd0);
      queue_req(OP_ENCODE, 8'd5, 31'd0);
      queue_req(OP_PREPARE, 8'd0, 31'd0);
      queue_req(OP_LOAD, 8'd0, 31'h7FFF_FFFF);
      queue_req(OP_LOAD, 8'd255, 31'h7FFF_FFFF);
      queue_req(OP_PREPARE, 8'hFF, 31'h7FFF_FFFF);
      queue_req(OP_ENCODE, 8'd0, 31'd0);
      queue_req(OP_LOAD, 8'd0, 31'h4000_0000);
      queue_req(OP_LOAD, 8'd255, 31'd0);
      queue_req(OP_PREPARE, 8'd0, 31'd0);
      queue_req(OP_ENCODE, 8'd0, 31'h5555_5555);
      queue_req(OP_ENCODE, 8'd1, 31'd0);
      queue_req(OP_ENCODE, 8'd255, 31'd0);
      queue_req(OP_FINISH, 8'd0, 31'd0);
      queue_req(OP_LOAD, 8'd0, 31'd1);
      queue_req(OP_LOAD, 8'd128, 31'd3);
      queue_req(OP_PREPARE, 8'd0, 31'd0);
      queue_req(OP_ENCODE, 8'd128, 31'd0);
      queue_req(OP_ENCODE, 8'd0, 31'd0);
      queue_req(OP_ENCODE, 8'd77, 31'd0);
      queue_req(OP_FINISH, 8'hAA, 31'h2AAA_AAAA);
      // Random part: streams over small models, with some noise.
      while (pending_reqs.size() < 420) begin
         queue_model(used);
         for (int k = $urandom_range(5, 40); k > 0; k--) begin
            case ($urandom_range(0, 19))
               0: queue_req(OP_ENCODE, 8'($urandom), 31'($urandom));
               1: queue_req(OP_LOAD, 8'($urandom), 31'($urandom));
               2: queue_req(OP_FINISH, 8'($urandom), 31'($urandom));
               default: queue_req(OP_ENCODE, used[$urandom_range(0, used.size() - 1)],
                                  31'($urandom));
            endcase
         end
         queue_req(OP_FINISH, 8'd0, 31'd0);
      end
      stimulus_done = 1;
   end

   initial begin
      for (int i = 0; i < 256; i++) freq_table[i] = 0;
      for (int i = 0; i < 257; i++) cum_table[i] = 0;
      model_total = 0;
      low_reg = 0;
      high_reg = TOP_VAL;
      follow_reg = 0;
      reset = 1;
      req_bus.valid = 0;
      req_bus.opcode = OP_LOAD;
      req_bus.symbol = 0;
      req_bus.count = 0;
      rsp_bus.ready = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
   end

   // Request driver.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_encoder(pending_reqs.pop_front());
            send_gap = pick_gap();
         end
         if ((!req_bus.valid || req_bus.ready) ) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 0;
            end else if (pending_reqs.size() > 0 &&
                         !(req_bus.valid && req_bus.ready && pending_reqs.size() == 0)) begin
               req_bus.valid <= 1;
               req_bus.opcode <= pending_reqs[0].opcode;
               req_bus.symbol <= pending_reqs[0].symbol;
               req_bus.count <= pending_reqs[0].count;
            end else begin
               req_bus.valid <= 0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = make_rsp(rsp_bus.kind, rsp_bus.bit_res, rsp_bus.follow_count,
                           rsp_bus.status, rsp_bus.last);
            if (coded_expect.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, got);
               error_count++;
            end else begin
               want = coded_expect.pop_front();
               if (got.kind !== want.kind)
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
               if (got.bit_res !== want.bit_res)
                  $display("%0t: bit_res expected %0d actual %0d", $time,
                           want.bit_res, got.bit_res);
               if (got.follow_count !== want.follow_count)
                  $display("%0t: follow_count expected %0d actual %0d", $time,
                           want.follow_count, got.follow_count);
               if (got.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
               if (got.last !== want.last)
                  $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
               if (got !== want) error_count++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 0;
         end else begin
            rsp_bus.ready <= 1;
            if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
         end
      end
   end

   // Watchdog and end of run.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge reset);
      while (!(stimulus_done && pending_reqs.size() == 0 && !req_bus.valid &&
               coded_expect.size() == 0)) begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
      repeat (200) @(posedge clock);
      if (error_count == 0 && coded_expect.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
